### hw/rtl/ifla_pkg.sv
// ----------------------------------------------------------------------------
// ifla_pkg
// Shared types and constants of the index free-list allocator: widths, the
// nil link mark, item kinds, result codes, controller states and the link
// memory access bundle.
// ----------------------------------------------------------------------------
package ifla_pkg;

    localparam int POOL_DEPTH = 1024;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int LINK_W     = IDX_W + 1;

    // Nil link mark: one past the last slot
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(POOL_DEPTH);

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_BUILD = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_POP   = 3'b010,
        ST_BUILD = 3'b100
    } state_t;

    // One write port and one read port of the link memory
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [LINK_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } ram_req_t;

endpackage

### hw/rtl/ifla_if.sv
// ----------------------------------------------------------------------------
// ifla_if
// Valid/ready channels of the allocator: request beats, result beats and
// pool size configuration beats.
// ----------------------------------------------------------------------------
interface ifla_req_if;
    import ifla_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       kind;
    logic [IDX_W-1:0] slot_index;

    modport source (output valid, output kind, output slot_index, input ready);
    modport sink   (input valid, input kind, input slot_index, output ready);
endinterface

interface ifla_rsp_if;
    import ifla_pkg::*;

    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  granted_index;
    logic [1:0]        status;
    logic [LINK_W-1:0] live_count;

    modport source (output valid, output granted_index, output status,
                    output live_count, input ready);
    modport sink   (input valid, input granted_index, input status,
                    input live_count, output ready);
endinterface

interface ifla_cfg_if;
    import ifla_pkg::*;

    logic              valid;
    logic              ready;
    logic [LINK_W-1:0] pool_size;

    modport source (output valid, output pool_size, input ready);
    modport sink   (input valid, input pool_size, output ready);
endinterface

### hw/rtl/ifla_link_ram.sv
// ----------------------------------------------------------------------------
// ifla_link_ram
// Link memory of the free list: one write port and one read port, read data
// registered. Contents are not reset.
// ----------------------------------------------------------------------------
module ifla_link_ram
(
    input  logic                           clk,
    input  ifla_pkg::ram_req_t             req,
    output logic [ifla_pkg::LINK_W-1:0]    rd_data
);
    import ifla_pkg::*;

    logic [LINK_W-1:0] mem [POOL_DEPTH];
    logic [LINK_W-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/index_free_list_allocator.sv
// ----------------------------------------------------------------------------
// index_free_list_allocator
// Pool of slots kept as a singly linked free list of indices in a link memory.
// Allocate pops the head, free pushes a slot, rebuild relinks the whole pool.
// ----------------------------------------------------------------------------
// Sequence: free, failed allocate and unused kind register their result directly;
//   successful allocate reads the head's link (ST_POP) first; rebuild writes one
//   link per cycle, then the result. One item in flight: the next
//   request is taken in the cycle its result beat leaves.
// Reset: list empty (head nil), live count 0, pool_size 1024; link memory
//   contents are not cleared.
// ----------------------------------------------------------------------------
module index_free_list_allocator
(
    input  logic         clk,
    input  logic         rst_n,
    ifla_req_if.sink     req,
    ifla_rsp_if.source   rsp,
    ifla_cfg_if.sink     cfg
);
    import ifla_pkg::*;

    state_t            state_reg,     state_next;
    logic [LINK_W-1:0] head_reg,      head_next;
    logic [LINK_W-1:0] count_reg,     count_next;
    logic [LINK_W-1:0] size_reg;
    logic [IDX_W-1:0]  build_reg,     build_next;
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  out_index_reg, out_index_next;
    status_t           out_status_reg, out_status_next;
    logic [LINK_W-1:0] out_count_reg, out_count_next;

    ram_req_t          ram_req;
    logic [LINK_W-1:0] ram_rd_data;

    logic              accept;
    logic [LINK_W-1:0] size_eff;
    logic [IDX_W-1:0]  size_last;
    logic              slot_in_range;
    logic [LINK_W-1:0] count_inc;
    logic [LINK_W-1:0] count_dec;
    logic              build_last;

    ifla_link_ram u_link_ram
    (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    // Clamp the pool size to 1 .. POOL_DEPTH
    always_comb
    begin
        if (size_reg == '0)
        begin
            size_eff = LINK_W'(1);
        end
        else if (size_reg > NIL_LINK)
        begin
            size_eff = NIL_LINK;
        end
        else
        begin
            size_eff = size_reg;
        end
    end

    assign size_last     = IDX_W'(size_eff - LINK_W'(1));
    assign slot_in_range = ({1'b0, req.slot_index} < size_eff);
    assign count_inc     = (count_reg == NIL_LINK) ? count_reg : count_reg + LINK_W'(1);
    assign count_dec     = (count_reg == '0) ? count_reg : count_reg - LINK_W'(1);
    assign build_last    = (build_reg == size_last);

    // Take a request only when idle and the result register is free or draining
    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    // Sequence the items and drive the link memory
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        build_next      = build_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_index_next  = out_index_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        ram_req         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind_t'(req.kind))
                        KIND_ALLOC:
                        begin
                            if (head_reg[IDX_W])
                            begin
                                out_valid_next  = 1'b1;
                                out_index_next  = '0;
                                out_status_next = STATUS_EMPTY;
                                out_count_next  = count_reg;
                            end
                            else
                            begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = head_reg[IDX_W-1:0];
                                state_next    = ST_POP;
                            end
                        end
                        KIND_FREE:
                        begin
                            out_valid_next = 1'b1;
                            out_index_next = '0;
                            if (slot_in_range)
                            begin
                                ram_req.we      = 1'b1;
                                ram_req.waddr   = req.slot_index;
                                ram_req.wdata   = head_reg;
                                head_next       = {1'b0, req.slot_index};
                                count_next      = count_dec;
                                out_status_next = STATUS_OK;
                                out_count_next  = count_dec;
                            end
                            else
                            begin
                                out_status_next = STATUS_RANGE;
                                out_count_next  = count_reg;
                            end
                        end
                        KIND_BUILD:
                        begin
                            build_next = '0;
                            state_next = ST_BUILD;
                        end
                        KIND_NONE:
                        begin
                            out_valid_next  = 1'b1;
                            out_index_next  = '0;
                            out_status_next = STATUS_OK;
                            out_count_next  = count_reg;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                // Advance the head to the link just read
                head_next       = ram_rd_data[IDX_W] ? NIL_LINK : ram_rd_data;
                count_next      = count_inc;
                out_valid_next  = 1'b1;
                out_index_next  = head_reg[IDX_W-1:0];
                out_status_next = STATUS_OK;
                out_count_next  = count_inc;
                state_next      = ST_IDLE;
            end
            ST_BUILD:
            begin
                // Link one slot per cycle, nil on the last
                ram_req.we    = 1'b1;
                ram_req.waddr = build_reg;
                ram_req.wdata = build_last ? NIL_LINK : {1'b0, build_reg} + LINK_W'(1);
                if (build_last)
                begin
                    head_next       = '0;
                    count_next      = '0;
                    out_valid_next  = 1'b1;
                    out_index_next  = '0;
                    out_status_next = STATUS_OK;
                    out_count_next  = '0;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    build_next = build_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= NIL_LINK;
            count_reg     <= '0;
            size_reg      <= LINK_W'(POOL_DEPTH);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                size_reg <= cfg.pool_size;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        build_reg      <= build_next;
        out_index_reg  <= out_index_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.granted_index = out_index_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.live_count    = out_count_reg;

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the index free-list allocator. Request, result and
// pool size channels are driven through their interfaces with random idles
// and stalls; an internal free-list model predicts every result beat, which
// is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ifla_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]  granted;
        status_t           status;
        logic [LINK_W-1:0] live;
    } grant_t;

    logic clk;
    logic rst_n;

    ifla_req_if req_ch ();
    ifla_rsp_if rsp_ch ();
    ifla_cfg_if cfg_ch ();

    index_free_list_allocator DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Free-list model state
    logic [LINK_W-1:0] link_mem [POOL_DEPTH];
    logic [LINK_W-1:0] list_head;
    logic [LINK_W-1:0] live_slots;
    logic [LINK_W-1:0] size_reg;

    grant_t            pending_grants [$];
    logic [IDX_W-1:0]  held_slots [$];
    int                fail_count;
    bit                idle_on;

    // Generate clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // End the run if it hangs
    initial
    begin
        #(20_000_000);
        $display("simulation failed");
        $finish;
    end

    function automatic int eff_size();
        if (size_reg == 0)
            return 1;
        if (size_reg > POOL_DEPTH)
            return POOL_DEPTH;
        return int'(size_reg);
    endfunction

    // Apply one request to the model and return the result it yields
    function automatic grant_t next_grant(kind_t k, logic [IDX_W-1:0] s);
        grant_t g;
        int     eff;
        g.granted = '0;
        g.status  = STATUS_OK;
        eff       = eff_size();
        case (k)
            KIND_ALLOC:
            begin
                if (list_head >= NIL_LINK)
                    g.status = STATUS_EMPTY;
                else
                begin
                    g.granted = list_head[IDX_W-1:0];
                    list_head = link_mem[list_head[IDX_W-1:0]];
                    if (list_head > NIL_LINK)
                        list_head = NIL_LINK;
                    if (live_slots < POOL_DEPTH)
                        live_slots = live_slots + 1'b1;
                end
            end
            KIND_FREE:
            begin
                if (int'(s) < eff)
                begin
                    link_mem[s] = list_head;
                    list_head   = LINK_W'(s);
                    if (live_slots > 0)
                        live_slots = live_slots - 1'b1;
                end
                else
                    g.status = STATUS_RANGE;
            end
            KIND_BUILD:
            begin
                for (int i = 0; i < eff - 1; i++)
                    link_mem[i] = LINK_W'(i + 1);
                link_mem[eff - 1] = NIL_LINK;
                list_head  = '0;
                live_slots = '0;
            end
            default:
            begin
            end
        endcase
        g.live = live_slots;
        return g;
    endfunction

    // Send one request beat and record its expected result
    task automatic send_item(kind_t k, logic [IDX_W-1:0] s);
        grant_t g;
        int     gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= k;
        req_ch.slot_index <= s;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        g = next_grant(k, s);
        pending_grants.push_back(g);
        if (k == KIND_ALLOC && g.status == STATUS_OK)
            held_slots.push_back(g.granted);
        if (k == KIND_BUILD)
            held_slots.delete();
    endtask

    // Hold off requests until every result beat is back
    task automatic wait_drain();
        req_ch.valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the pool size while the block is idle
    task automatic write_size(logic [LINK_W-1:0] v);
        wait_drain();
        cfg_ch.valid     <= 1'b1;
        cfg_ch.pool_size <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        size_reg = v;
    endtask

    task automatic report_field(string name, int exp_v, int act_v);
        fail_count++;
        if (fail_count <= 50)
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
    endtask

    // Compare each result beat with the oldest expectation
    initial
    begin
        grant_t g;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_grants.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 50)
                        $display("%0t: result expected none actual index %0d status %0d count %0d",
                                 $time, rsp_ch.granted_index, rsp_ch.status,
                                 rsp_ch.live_count);
                end
                else
                begin
                    g = pending_grants.pop_front();
                    if (rsp_ch.granted_index !== g.granted)
                        report_field("granted_index", g.granted, rsp_ch.granted_index);
                    if (rsp_ch.status !== g.status)
                        report_field("status", g.status, rsp_ch.status);
                    if (rsp_ch.live_count !== g.live)
                        report_field("live_count", g.live, rsp_ch.live_count);
                end
            end
        end
    end

    // Stall the result side in random bursts
    initial
    begin
        int stall;
        stall = 0;
        rsp_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                stall--;
                rsp_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(0, 15);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Reset behavior, every kind, range and empty cases, size change after rebuild
    task automatic test_directed();
        idle_on = 1'b1;
        send_item(KIND_ALLOC, 10'd0);
        send_item(KIND_FREE, 10'd1023);
        send_item(KIND_ALLOC, 10'd1023);
        send_item(KIND_ALLOC, 10'd0);
        write_size(11'd4);
        send_item(KIND_BUILD, 10'd1023);
        repeat (4) send_item(KIND_ALLOC, IDX_W'($urandom_range(0, 1023)));
        send_item(KIND_ALLOC, 10'd0);
        send_item(KIND_FREE, 10'd3);
        send_item(KIND_FREE, 10'd4);
        send_item(KIND_FREE, 10'd1023);
        send_item(KIND_NONE, 10'd1023);
        send_item(KIND_ALLOC, 10'd0);
        send_item(KIND_FREE, 10'd0);
        send_item(KIND_FREE, 10'd0);
        // Shrink the pool with slots beyond the new size still on the list
        write_size(11'd8);
        send_item(KIND_BUILD, 10'd0);
        write_size(11'd2);
        repeat (3) send_item(KIND_ALLOC, 10'd0);
        send_item(KIND_FREE, 10'd2);
        // Zero size acts as one slot
        write_size(11'd0);
        send_item(KIND_BUILD, 10'd0);
        send_item(KIND_ALLOC, 10'd0);
        send_item(KIND_ALLOC, 10'd0);
        send_item(KIND_FREE, 10'd1);
        send_item(KIND_FREE, 10'd0);
    endtask

    // Rebuild at one size, then mostly well-formed pops and pushes with noise
    task automatic run_phase(logic [LINK_W-1:0] size, int count, int alloc_weight);
        int               pick;
        int               idx;
        int               s;
        logic [IDX_W-1:0] slot;
        write_size(size);
        send_item(KIND_BUILD, IDX_W'($urandom_range(0, 1023)));
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
                write_size(LINK_W'($urandom_range(1, 40)));
            else if (pick < 5)
                wait_drain();
            pick = $urandom_range(0, 99);
            slot = IDX_W'($urandom_range(0, 1023));
            if (pick < alloc_weight)
                send_item(KIND_ALLOC, slot);
            else if (pick < 88)
            begin
                if (held_slots.size() == 0)
                    send_item(KIND_ALLOC, slot);
                else
                begin
                    idx  = $urandom_range(0, held_slots.size() - 1);
                    slot = held_slots[idx];
                    held_slots.delete(idx);
                    send_item(KIND_FREE, slot);
                end
            end
            else if (pick < 92)
                send_item(KIND_FREE, slot);
            else if (pick < 95)
            begin
                s = eff_size() + $urandom_range(0, 3);
                if (s > 1023)
                    s = $urandom_range(0, 1023);
                send_item(KIND_FREE, IDX_W'(s));
            end
            else if (pick < 98)
                send_item(KIND_NONE, slot);
            else
                send_item(KIND_BUILD, slot);
        end
    endtask

    task automatic test_random();
        idle_on = 1'b1;
        run_phase(11'd1, 40, 50);
        run_phase(11'd2, 50, 50);
        run_phase(LINK_W'($urandom_range(3, 16)), 70, 40);
        run_phase(LINK_W'($urandom_range(17, 64)), 70, 60);
        run_phase(11'd0, 40, 50);
        run_phase(11'd2047, 60, 50);
        run_phase(11'd1024, 70, 55);
        idle_on = 1'b0;
        run_phase(LINK_W'($urandom_range(5, 30)), 60, 50);
        idle_on = 1'b1;
        run_phase(LINK_W'($urandom_range(5, 12)), 80, 35);
        run_phase(11'd1500, 60, 45);
    endtask

    // Free a slot with the count at zero, loop it onto itself and pop it repeatedly
    task automatic test_count_saturation();
        idle_on = 1'b0;
        write_size(11'd1);
        send_item(KIND_BUILD, 10'd0);
        send_item(KIND_FREE, 10'd0);
        repeat (20) send_item(KIND_ALLOC, IDX_W'($urandom_range(0, 1023)));
        send_item(KIND_FREE, 10'd0);
        send_item(KIND_ALLOC, 10'd0);
    endtask

    // Reset, run the tests, drain and report
    initial
    begin
        int waited;
        fail_count = 0;
        idle_on    = 1'b0;
        size_reg   = LINK_W'(POOL_DEPTH);
        list_head  = NIL_LINK;
        live_slots = '0;
        for (int i = 0; i < POOL_DEPTH; i++)
            link_mem[i] = '0;
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.kind       <= KIND_ALLOC;
        req_ch.slot_index <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.pool_size  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random();
        test_count_saturation();

        req_ch.valid <= 1'b0;
        waited = 0;
        while (pending_grants.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (64) @(posedge clk);
        if (pending_grants.size() != 0)
        begin
            $display("%0t: results expected %0d more actual 0", $time, pending_grants.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
